// ===== hdl/qaa_pkg.sv =====
// Package for the quaternion to axis-angle unit: shared constants and the CORDIC angle table.
// No dependencies.
`default_nettype none
package qaa_pkg;
   localparam int CordicSteps = 24;
   localparam int ZWidth      = 28;
   localparam int AngleWidth  = 16;
   localparam int AxisLimitWidth = 31;
   localparam int HalfLimitWidth = 15;
   localparam logic [ZWidth-1:0] HalfPiZ = 28'd26353589;
   localparam logic [AngleWidth-1:0] PiAngle = 16'd25736;
   localparam logic [AngleWidth-1:0] TwoPiAngle = 16'd51472;

   typedef enum logic [0:0] {
      CSR_AXIS_LIMIT = 1'b0,
      CSR_HALF_TURN_LIMIT = 1'b1
   } csr_index_type;

   // atan(2^-i) in units of 2^-24 rad
   function automatic logic [ZWidth-1:0] atan_entry(input logic [4:0] idx);
      logic [ZWidth-1:0] v;
      begin
         unique case (idx)
            5'd0: v = 28'd13176795;
            5'd1: v = 28'd7778716;
            5'd2: v = 28'd4110060;
            5'd3: v = 28'd2086331;
            5'd4: v = 28'd1047214;
            5'd5: v = 28'd524117;
            5'd6: v = 28'd262123;
            5'd7: v = 28'd131069;
            default: v = ZWidth'(28'd1) << (5'd24 - idx);
         endcase
         atan_entry = v;
      end
   endfunction
endpackage
`default_nettype wire

// ===== hdl/quaternion_to_axis_angle_unit.sv =====
// Top level of the quaternion to axis-angle unit: square, root, divide and CORDIC pipeline.
// Depends on qaa_pkg and the stage modules qaa_isqrt_stage, qaa_div_stage, qaa_cordic_stage.
//
//  channel | ports                                      | direction
//  request | req_valid, req_stall, req_quat_*           | in
//  result  | rsp_valid, rsp_stall, rsp_turn_angle, rsp_axis_*, rsp_degenerate | out
//  config  | csr_write, csr_index, csr_data             | in
//
// A request, once accepted, passes these registered steps: input, square, sum/compare,
// RSt = CW+1 root digits, the longer of NumW = 2*CW-1 quotient bits and 24 CORDIC steps,
// one alignment register, output. One request per cycle while the output is not stalled.
// A stall freezes the entire pipeline; reset sets both limits to 1, clears only valid bits.
`default_nettype none
module quaternion_to_axis_angle_unit #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic             [15:0]                rsp_turn_angle,
   output logic signed      [COMPONENT_WIDTH-1:0] rsp_axis_x,
   output logic signed      [COMPONENT_WIDTH-1:0] rsp_axis_y,
   output logic signed      [COMPONENT_WIDTH-1:0] rsp_axis_z,
   output logic                                   rsp_degenerate,
   input  wire logic                              csr_write,
   input  wire logic                              csr_index,
   input  wire logic        [30:0]                csr_data
);
   localparam int Cw   = COMPONENT_WIDTH;
   localparam int Fb   = Cw - 1;
   localparam int S2w  = 2*Cw + 2;       // room for three squares
   localparam int RadW = S2w + (S2w % 2);
   localparam int RSt  = RadW / 2;
   localparam int NumW = 2*Fb + 1;       // |c| << Fb
   localparam int DenW = Cw;
   localparam int Kx   = 38 - Fb;
   localparam int XyW  = Cw + Kx + 4;
   localparam int Zw   = qaa_pkg::ZWidth;
   localparam int Cs   = qaa_pkg::CordicSteps;
   localparam int Lag  = ((NumW > Cs) ? NumW : Cs) + 1;
   localparam int P1   = 2 + RSt;        // stage holding the root
   localparam int P2   = P1 + Lag;       // stage where axis and angle meet
   localparam int Dly  = Lag - Cs;       // angle delay, at least one
   localparam int QDly = Lag - NumW;     // quotient delay, at least one
   localparam int Lat  = P2 + 2;
   localparam int CmpW = (2*Fb >= 30) ? S2w + 31 : S2w + 31;

   logic [30:0] axis_limit_ff;
   logic [14:0] half_limit_ff;
   logic        adv;
   logic [Lat-1:0] vld_ff;

   assign adv       = !rsp_stall || !rsp_valid;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_limit_ff <= 31'd1;
         half_limit_ff <= 15'd1;
      end else if (csr_write) begin
         unique case (qaa_pkg::csr_index_type'(csr_index))
            qaa_pkg::CSR_AXIS_LIMIT:      axis_limit_ff <= csr_data;
            qaa_pkg::CSR_HALF_TURN_LIMIT: half_limit_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Lat-2:0], req_valid};
   end

   // stage 0: register inputs
   logic signed [Cw-1:0] c_ff [3];
   logic signed [Cw-1:0] w0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff[0] <= req_quat_x;
         c_ff[1] <= req_quat_y;
         c_ff[2] <= req_quat_z;
         w0_ff   <= req_quat_w;
      end
   end

   // stage 1: squares
   logic [2*Cw-1:0] sq_ff [3];
   logic signed [Cw-1:0] c1_ff [3];
   logic signed [Cw-1:0] w1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= $unsigned((2*Cw)'(c_ff[i]) * (2*Cw)'(c_ff[i]));
            c1_ff[i] <= c_ff[i];
         end
         w1_ff <= w0_ff;
      end
   end

   // stage 2: sum and threshold compares
   logic [S2w-1:0] s2_sum;
   logic [CmpW-1:0] lhs, rhs;
   logic [Cw:0] wabs;
   logic [Cw+15:0] wl, wr;
   always_comb begin
      s2_sum = S2w'(sq_ff[0]) + S2w'(sq_ff[1]) + S2w'(sq_ff[2]);
      if (2*Fb >= 30) begin
         lhs = CmpW'(s2_sum);
         rhs = CmpW'(axis_limit_ff) << (2*Fb - 30);
      end else begin
         lhs = CmpW'(s2_sum) << (30 - 2*Fb);
         rhs = CmpW'(axis_limit_ff);
      end
      wabs = w1_ff[Cw-1] ? (Cw+1)'(-$signed({w1_ff[Cw-1], w1_ff}))
                         : (Cw+1)'({1'b0, w1_ff});
      if (Fb >= 15) begin
         wl = (Cw+16)'(wabs);
         wr = (Cw+16)'(half_limit_ff) << (Fb - 15);
      end else begin
         wl = (Cw+16)'(wabs) << (15 - Fb);
         wr = (Cw+16)'(half_limit_ff);
      end
   end

   logic [RadW-1:0] rad_ff;
   logic            deg_ff [2:P2];
   logic            half_ff [2:P2];
   logic signed [Cw-1:0] cp_ff [2:P2][3];
   logic signed [Cw-1:0] wp_ff [2:P2];
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff     <= RadW'(s2_sum);
         deg_ff[2]  <= (lhs < rhs) || (s2_sum == '0);
         half_ff[2] <= wl < wr;
         cp_ff[2]   <= c1_ff;
         wp_ff[2]   <= w1_ff;
         for (int k = 3; k <= P2; k++) begin
            deg_ff[k]  <= deg_ff[k-1];
            half_ff[k] <= half_ff[k-1];
            cp_ff[k]   <= cp_ff[k-1];
            wp_ff[k]   <= wp_ff[k-1];
         end
      end
   end

   // root: stages 3 .. 2+RSt
   logic [RadW-1:0] rem_w  [RSt+1];
   logic [RadW-1:0] root_w [RSt+1];
   assign rem_w[0]  = rad_ff;
   assign root_w[0] = '0;
   for (genvar g = 0; g < RSt; g++) begin : g_root
      qaa_isqrt_stage #(.RadWidth(RadW), .Step(g)) u_st (
         .clock(clock), .enable(adv),
         .rem_in_d(rem_w[g]), .root_in_d(root_w[g]),
         .rem_ff(rem_w[g+1]), .root_ff(root_w[g+1]));
   end
   logic [DenW-1:0] s_root;
   assign s_root = DenW'(root_w[RSt]);

   // dividers: three lanes, den carried along
   logic [DenW-1:0] den_w  [NumW];
   logic [DenW-1:0] den_ff [NumW-1];
   logic [NumW-1:0] num_w [3][NumW+1];
   logic [DenW:0]   rem_d [3][NumW+1];
   assign den_w[0] = (s_root == '0) ? DenW'(1) : s_root;
   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [Cw-1:0] mag;
      assign mag = cp_ff[P1][l][Cw-1] ? Cw'(-cp_ff[P1][l]) : Cw'(cp_ff[P1][l]);
      assign num_w[l][0] = NumW'({mag, {Fb{1'b0}}});
      assign rem_d[l][0] = '0;
      for (genvar b = 0; b < NumW; b++) begin : g_bit
         qaa_div_stage #(.NumWidth(NumW), .DenWidth(DenW)) u_div (
            .clock(clock), .enable(adv),
            .num_in_d(num_w[l][b]), .rem_in_d(rem_d[l][b]), .den(den_w[b]),
            .num_ff(num_w[l][b+1]), .rem_ff(rem_d[l][b+1]));
      end
   end
   for (genvar b = 0; b < NumW-1; b++) begin : g_den
      assign den_w[b+1] = den_ff[b];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff[0] <= den_w[0];
         for (int k = 1; k < NumW-1; k++) den_ff[k] <= den_ff[k-1];
      end
   end

   // axis from quotients
   logic signed [Cw-1:0] axis_c [3];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         logic [NumW-1:0] q;
         logic [Cw-1:0] qs;
         q  = num_w[l][NumW];
         qs = (q > NumW'({Fb{1'b1}})) ? Cw'({Fb{1'b1}}) : Cw'(q);
         axis_c[l] = cp_ff[P1+NumW][l][Cw-1] ? $signed(Cw'(-qs)) : $signed(qs);
      end
   end

   // delay axis to the meeting stage
   logic signed [Cw-1:0] axq_ff [QDly][3];
   always_ff @(posedge clock) begin
      if (adv) begin
         axq_ff[0] <= axis_c;
         for (int k = 1; k < QDly; k++) axq_ff[k] <= axq_ff[k-1];
      end
   end

   // CORDIC, parallel to divider: start from stage P1
   logic signed [XyW-1:0] cx [Cs+1];
   logic signed [XyW-1:0] cy [Cs+1];
   logic signed [Zw:0]    cz [Cs+1];
   logic signed [XyW-1:0] ws, ss;
   assign ws = XyW'(wp_ff[P1]) <<< Kx;
   assign ss = $signed(XyW'({1'b0, s_root})) <<< Kx;
   assign cx[0] = wp_ff[P1][Cw-1] ? ss : ws;
   assign cy[0] = wp_ff[P1][Cw-1] ? -ws : ss;
   assign cz[0] = wp_ff[P1][Cw-1] ? $signed({1'b0, qaa_pkg::HalfPiZ}) : '0;
   for (genvar g = 0; g < Cs; g++) begin : g_cor
      qaa_cordic_stage #(.XyWidth(XyW), .Step(g)) u_cs (
         .clock(clock), .enable(adv),
         .x_d(cx[g]), .y_d(cy[g]), .z_d(cz[g]),
         .x_ff(cx[g+1]), .y_ff(cy[g+1]), .z_ff(cz[g+1]));
   end
   // delay angle to the meeting stage
   logic [15:0] ang_ff [Dly];
   logic [Zw:0] zc;
   logic [Zw-9:0] rnd;
   logic [15:0] ang_in;
   always_comb begin
      zc  = cz[Cs][Zw] ? '0 : cz[Cs];
      rnd = (Zw-8)'((zc + (Zw+1)'(512)) >> 10);
      ang_in = (rnd > (Zw-8)'(qaa_pkg::TwoPiAngle)) ? qaa_pkg::TwoPiAngle : 16'(rnd);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff[0] <= ang_in;
         for (int k = 1; k < Dly; k++) ang_ff[k] <= ang_ff[k-1];
      end
   end

   // output register
   logic [15:0] o_ang_ff;
   logic signed [Cw-1:0] o_ax_ff [3];
   logic o_deg_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         o_deg_ff <= deg_ff[P2];
         if (deg_ff[P2]) begin
            o_ang_ff   <= '0;
            o_ax_ff[0] <= Cw'({Fb{1'b1}});
            o_ax_ff[1] <= '0;
            o_ax_ff[2] <= '0;
         end else begin
            o_ang_ff <= half_ff[P2] ? qaa_pkg::PiAngle : ang_ff[Dly-1];
            o_ax_ff  <= axq_ff[QDly-1];
         end
      end
   end
   assign rsp_turn_angle = o_ang_ff;
   assign rsp_axis_x = o_ax_ff[0];
   assign rsp_axis_y = o_ax_ff[1];
   assign rsp_axis_z = o_ax_ff[2];
   assign rsp_degenerate = o_deg_ff;
endmodule
`default_nettype wire

// ===== hdl/qaa_isqrt_stage.sv =====
// One registered digit step of the restoring square root: two bits of radicand per step.
// Uses no package items.
`default_nettype none
module qaa_isqrt_stage #(
   parameter int RadWidth = 64,
   parameter int Step     = 0
) (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire logic [RadWidth-1:0] rem_in_d,
   input  wire logic [RadWidth-1:0] root_in_d,
   output logic      [RadWidth-1:0] rem_ff,
   output logic      [RadWidth-1:0] root_ff
);
   localparam int Shift = RadWidth - 2 - 2*Step;
   logic [RadWidth-1:0] bit_val;
   logic [RadWidth-1:0] trial;
   logic [RadWidth-1:0] rem_in;
   logic [RadWidth-1:0] root_in;

   // root kept in scaled form: r holds root scaled by bit position
   always_comb begin
      bit_val = RadWidth'(1) << Shift;
      trial   = root_in_d + bit_val;
      if (rem_in_d >= trial) begin
         rem_in  = rem_in_d - trial;
         root_in = (root_in_d >> 1) + bit_val;
      end else begin
         rem_in  = rem_in_d;
         root_in = root_in_d >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/qaa_div_stage.sv =====
// One registered step of a restoring divider: one quotient bit per step.
// Uses no package items.
`default_nettype none
module qaa_div_stage #(
   parameter int NumWidth = 32,
   parameter int DenWidth = 16
) (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire logic [NumWidth-1:0] num_in_d,
   input  wire logic [DenWidth:0]   rem_in_d,
   input  wire logic [DenWidth-1:0] den,
   output logic      [NumWidth-1:0] num_ff,
   output logic      [DenWidth:0]   rem_ff
);
   logic [DenWidth+1:0] shifted;
   logic [NumWidth-1:0] num_in;
   logic [DenWidth:0]   rem_in;

   always_comb begin
      shifted = {rem_in_d, num_in_d[NumWidth-1]};
      if (shifted >= {2'b00, den}) begin
         rem_in = (DenWidth+1)'(shifted - {2'b00, den});
         num_in = {num_in_d[NumWidth-2:0], 1'b1};
      end else begin
         rem_in = shifted[DenWidth:0];
         num_in = {num_in_d[NumWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/qaa_cordic_stage.sv =====
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// Depends on qaa_pkg for the angle table.
`default_nettype none
module qaa_cordic_stage #(
   parameter int XyWidth = 48,
   parameter int Step    = 0
) (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic signed [XyWidth-1:0]     x_d,
   input  wire logic signed [XyWidth-1:0]     y_d,
   input  wire logic signed [qaa_pkg::ZWidth:0] z_d,
   output logic signed      [XyWidth-1:0]     x_ff,
   output logic signed      [XyWidth-1:0]     y_ff,
   output logic signed      [qaa_pkg::ZWidth:0] z_ff
);
   logic signed [XyWidth-1:0] xs;
   logic signed [XyWidth-1:0] ys;
   logic signed [qaa_pkg::ZWidth:0] at;
   logic signed [XyWidth-1:0] x_in;
   logic signed [XyWidth-1:0] y_in;
   logic signed [qaa_pkg::ZWidth:0] z_in;

   always_comb begin
      xs = x_d >>> Step;
      ys = y_d >>> Step;
      at = $signed({1'b0, qaa_pkg::atan_entry(5'(Step))});
      if (!y_d[XyWidth-1]) begin
         x_in = x_d + ys;
         y_in = y_d - xs;
         z_in = z_d + at;
      end else begin
         x_in = x_d - ys;
         y_in = y_d + xs;
         z_in = z_d - at;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end
endmodule
`default_nettype wire
